/* design/dmfp_pkg.sv */
// ---------------------------------------------------------------------------
// DNS message field parser package
// Shared types and constants for the byte-wise DNS message field parser.
// ---------------------------------------------------------------------------
package dmfp_pkg;

    // Message layout.
    localparam int HEADER_BYTES = 12;
    localparam int RDATA_KEEP   = 16;

    // The byte counter must hold the last header byte index and RDATA_KEEP.
    localparam int CNT_MAX = (RDATA_KEEP > HEADER_BYTES) ? RDATA_KEEP : HEADER_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    // Header byte indexes ending both counts and the header; RDATA keep limit.
    localparam logic [CNT_W-1:0] ANCOUNT_LAST_BYTE = CNT_W'(7);
    localparam logic [CNT_W-1:0] ARCOUNT_LAST_BYTE = CNT_W'(11);
    localparam logic [CNT_W-1:0] HEADER_LAST_BYTE  = CNT_W'(HEADER_BYTES - 1);
    localparam logic [CNT_W-1:0] RDATA_KEEP_CNT    = CNT_W'(RDATA_KEEP);

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Field kinds carried with each result word.
    localparam logic [3:0] KIND_NAME_CHAR = 4'd0;
    localparam logic [3:0] KIND_NAME_END  = 4'd1;
    localparam logic [3:0] KIND_ANCOUNT   = 4'd2;
    localparam logic [3:0] KIND_ARCOUNT   = 4'd3;
    localparam logic [3:0] KIND_QTYPE     = 4'd4;
    localparam logic [3:0] KIND_QCLASS    = 4'd5;
    localparam logic [3:0] KIND_ANS_PTR   = 4'd6;
    localparam logic [3:0] KIND_ANS_TYPE  = 4'd7;
    localparam logic [3:0] KIND_ANS_CLASS = 4'd8;
    localparam logic [3:0] KIND_TTL       = 4'd9;
    localparam logic [3:0] KIND_RDLENGTH  = 4'd10;
    localparam logic [3:0] KIND_RDATA     = 4'd11;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HEADER     = 4'd0,
        PH_LABEL_LEN  = 4'd1,
        PH_LABEL_CHAR = 4'd2,
        PH_QTYPE      = 4'd3,
        PH_QCLASS     = 4'd4,
        PH_ANS_PTR    = 4'd5,
        PH_ANS_TYPE   = 4'd6,
        PH_ANS_CLASS  = 4'd7,
        PH_TTL        = 4'd8,
        PH_RDLEN      = 4'd9,
        PH_RDATA      = 4'd10,
        PH_DONE       = 4'd11
    } phase_t;

    // One result word passed from the parser core to the output buffer.
    typedef struct packed {
        logic        valid;
        logic [3:0]  kind;
        logic [31:0] value;
    } result_t;

endpackage

/* design/dns_message_field_parser_unit.sv */
// ---------------------------------------------------------------------------
// DNS message field parser unit
// Reads a DNS message one byte per word and reports header counts, the
// question name, type and class, and the first answer's fixed fields and data.
// ---------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, data_byte,            | to block
//          | end_of_message                            |
//  out     | out_valid, out_stall, field_kind,         | from block
//          | field_value                               |
//
// One byte is taken per cycle while in_stall is low; its result word, if any,
// enters the output register in the following cycle, or the skid stage if busy.
// The parse state updates in a single pass, so the rate is one word per cycle.
// Reset returns the parser to the header phase and empties the output buffer.
// A two-word output buffer absorbs an output stall; in_stall rises only when
// both words are occupied.
// ---------------------------------------------------------------------------
module dns_message_field_parser_unit
    import dmfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    data_byte,
    input  logic          end_of_message,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [3:0]    field_kind,
    output logic [31:0]   field_value
);

    logic    accept;
    logic    buf_full;
    result_t result;

    // A word is taken whenever the output buffer has room for its result.
    assign in_stall = buf_full;
    assign accept   = in_valid & ~buf_full;

    dmfp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .result         (result)
    );

    dmfp_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .result      (result),
        .full        (buf_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .field_kind  (field_kind),
        .field_value (field_value)
    );

endmodule

/* design/dmfp_core.sv */
// ---------------------------------------------------------------------------
// DNS message field parser core
// Holds the parse state and turns each accepted byte into at most one result.
// ---------------------------------------------------------------------------
module dmfp_core
    import dmfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          end_of_message,
    output result_t       result
);

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         label_left_reg, label_left_next;
    logic               first_label_reg, first_label_next;
    logic               ans_nz_reg, ans_nz_next;
    logic [31:0]        gather_reg, gather_next;
    logic [15:0]        data_left_reg, data_left_next;

    logic [31:0]        gather_shift;
    logic               fixed_done;
    logic [7:0]         label_left_dec;
    logic [15:0]        data_left_dec;

    // Shared terms of the byte datapath.
    assign gather_shift   = {gather_reg[23:0], data_byte};
    assign fixed_done     = (phase_reg == PH_TTL) ? (count_reg == CNT_W'(3))
                                                  : (count_reg == CNT_W'(1));
    assign label_left_dec = label_left_reg - 8'd1;
    assign data_left_dec  = data_left_reg - 16'd1;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (count_reg == HEADER_LAST_BYTE)
                    phase_next = PH_LABEL_LEN;
            end
            PH_LABEL_LEN:
            begin
                phase_next = (data_byte == 8'd0) ? PH_QTYPE : PH_LABEL_CHAR;
            end
            PH_LABEL_CHAR:
            begin
                if (label_left_dec == 8'd0)
                    phase_next = PH_LABEL_LEN;
            end
            PH_QTYPE:     if (fixed_done) phase_next = PH_QCLASS;
            PH_QCLASS:    if (fixed_done) phase_next = ans_nz_reg ? PH_ANS_PTR : PH_DONE;
            PH_ANS_PTR:   if (fixed_done) phase_next = PH_ANS_TYPE;
            PH_ANS_TYPE:  if (fixed_done) phase_next = PH_ANS_CLASS;
            PH_ANS_CLASS: if (fixed_done) phase_next = PH_TTL;
            PH_TTL:       if (fixed_done) phase_next = PH_RDLEN;
            PH_RDLEN:
            begin
                if (fixed_done)
                    phase_next = (gather_shift[15:0] != 16'd0) ? PH_RDATA : PH_DONE;
            end
            PH_RDATA:
            begin
                if (data_left_dec == 16'd0)
                    phase_next = PH_DONE;
            end
            default: phase_next = PH_DONE;
        endcase
        if (end_of_message)
            phase_next = PH_HEADER;
    end

    // Counters, gathered bytes and the result word.
    always_comb
    begin
        count_next       = count_reg;
        label_left_next  = label_left_reg;
        first_label_next = first_label_reg;
        ans_nz_next      = ans_nz_reg;
        gather_next      = gather_reg;
        data_left_next   = data_left_reg;
        result           = '0;
        case (phase_reg)
            PH_HEADER:
            begin
                gather_next = gather_shift;
                if (count_reg == ANCOUNT_LAST_BYTE)
                begin
                    ans_nz_next  = (gather_shift[15:0] != 16'd0);
                    result.valid = 1'b1;
                    result.kind  = KIND_ANCOUNT;
                    result.value = {16'd0, gather_shift[15:0]};
                end
                else if (count_reg == ARCOUNT_LAST_BYTE)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_ARCOUNT;
                    result.value = {16'd0, gather_shift[15:0]};
                end
                if (count_reg == HEADER_LAST_BYTE)
                begin
                    count_next  = '0;
                    gather_next = '0;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            PH_LABEL_LEN:
            begin
                if (data_byte == 8'd0)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_NAME_END;
                    count_next   = '0;
                    gather_next  = '0;
                end
                else
                begin
                    // A separator dot goes out ahead of every label but the first.
                    if (!first_label_reg)
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_NAME_CHAR;
                        result.value = {24'd0, DOT_CHAR};
                    end
                    first_label_next = 1'b0;
                    label_left_next  = data_byte;
                end
            end
            PH_LABEL_CHAR:
            begin
                result.valid    = 1'b1;
                result.kind     = KIND_NAME_CHAR;
                result.value    = {24'd0, data_byte};
                label_left_next = label_left_dec;
            end
            PH_QTYPE, PH_QCLASS, PH_ANS_PTR, PH_ANS_TYPE, PH_ANS_CLASS, PH_TTL, PH_RDLEN:
            begin
                gather_next = gather_shift;
                count_next  = count_reg + CNT_W'(1);
                if (fixed_done)
                begin
                    result.valid = 1'b1;
                    case (phase_reg)
                        PH_QTYPE:     result.kind = KIND_QTYPE;
                        PH_QCLASS:    result.kind = KIND_QCLASS;
                        PH_ANS_PTR:   result.kind = KIND_ANS_PTR;
                        PH_ANS_TYPE:  result.kind = KIND_ANS_TYPE;
                        PH_ANS_CLASS: result.kind = KIND_ANS_CLASS;
                        PH_TTL:       result.kind = KIND_TTL;
                        default:      result.kind = KIND_RDLENGTH;
                    endcase
                    result.value = (phase_reg == PH_TTL) ? gather_shift
                                                         : {16'd0, gather_shift[15:0]};
                    count_next   = '0;
                    gather_next  = '0;
                    if (phase_reg == PH_RDLEN)
                        data_left_next = gather_shift[15:0];
                end
            end
            PH_RDATA:
            begin
                // Only the first RDATA_KEEP data bytes are reported.
                if (count_reg != RDATA_KEEP_CNT)
                begin
                    result.valid = 1'b1;
                    result.kind  = KIND_RDATA;
                    result.value = {24'd0, data_byte};
                    count_next   = count_reg + CNT_W'(1);
                end
                data_left_next = data_left_dec;
            end
            default:
            begin
            end
        endcase
        if (end_of_message)
        begin
            count_next       = '0;
            label_left_next  = '0;
            first_label_next = 1'b1;
            ans_nz_next      = 1'b0;
            gather_next      = '0;
            data_left_next   = '0;
        end
        result.valid = result.valid & accept;
    end

    // Parse state registers, updated on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            count_reg       <= '0;
            label_left_reg  <= '0;
            first_label_reg <= 1'b1;
            ans_nz_reg      <= 1'b0;
            gather_reg      <= '0;
            data_left_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            label_left_reg  <= label_left_next;
            first_label_reg <= first_label_next;
            ans_nz_reg      <= ans_nz_next;
            gather_reg      <= gather_next;
            data_left_reg   <= data_left_next;
        end
    end

endmodule

/* design/dmfp_outbuf.sv */
// ---------------------------------------------------------------------------
// DNS message field parser output buffer
// Result register with a skid stage so input and output stalls stay apart.
// ---------------------------------------------------------------------------
module dmfp_outbuf
    import dmfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  result_t       result,
    output logic          full,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [3:0]    field_kind,
    output logic [31:0]   field_value
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [35:0] main_data_reg, main_data_next;
    logic [35:0] skid_data_reg, skid_data_next;
    logic        out_take;

    assign out_take = main_valid_reg & ~out_stall;

    // Move words between the skid stage and the output register.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_take)
        begin
            main_valid_next = skid_valid_reg;
            main_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (result.valid)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_data_next  = {result.kind, result.value};
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = {result.kind, result.value};
            end
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Word payloads.
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full        = skid_valid_reg;
    assign out_valid   = main_valid_reg;
    assign field_kind  = main_data_reg[35:32];
    assign field_value = main_data_reg[31:0];

endmodule
